>>> hw/rtl/wssd_pkg.sv
// Package for the windowed span stall detector.
// History depth, derived widths, register indexes and reset values.
// No dependencies.
`default_nettype none

package wssd_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic REG_WINDOW_MS     = 1'b0;
   localparam logic REG_THRESHOLD_DEG = 1'b1;

   localparam logic [31:0] WINDOW_MS_RESET     = 32'd1000;
   localparam logic [30:0] THRESHOLD_DEG_RESET = 31'd5;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

endpackage

`default_nettype wire

>>> hw/rtl/windowed_span_stall_detector.sv
// Windowed span stall detector, top level: sample ring in two synchronous memories,
// a sequencer that walks the ring, an APB-style register port. Depends on wssd_pkg.
//
//   channel | direction | ports                                   | transfer
//   req     | in        | req_valid/req_stall, now_ms, angle_deg  | one sample
//   rsp     | out       | rsp_valid/rsp_stall, stalled            | one verdict per sample
//   csr     | in/out    | csr_psel/penable/pwrite/paddr/pwdata    | window, threshold
//
// The sequencer goes from idle straight to done when fewer than two samples are held,
// via the check to done when the oldest sample is inside the window, else via the
// check and a walk back over ring entries, the one that ends it included (at most
// DEPTH-1 = 15), one entry read per cycle. Reset is synchronous and empties the ring.
// A register write also empties it. A verdict waiting on rsp_stall does not block
// the next req transaction; the sequencer stays in done until its verdict is placed.
`default_nettype none

module windowed_span_stall_detector
   import wssd_pkg::*;
(
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire  [31:0]           req_now_ms,
   input  wire  signed [31:0]    req_angle_deg,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output logic                  rsp_stalled,
   input  wire                   csr_psel,
   input  wire                   csr_penable,
   input  wire                   csr_pwrite,
   input  wire  [CSR_ADDR_W-1:0] csr_paddr,
   input  wire  [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CHECK = 2'd1;
   localparam logic [1:0] ST_WALK  = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [31:0] time_mem  [DEPTH];
   logic [31:0] angle_mem [DEPTH];

   logic [1:0]         state_ff, state_in;
   idx_type            wp_ff, wp_in;
   cnt_type            fill_ff, fill_in;
   cnt_type            step_ff, step_in;
   cnt_type            inwin_ff, inwin_in;
   logic [31:0]        now_ff, now_in;
   logic signed [31:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [31:0]        window_ff;
   logic [30:0]        thresh_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_stalled_ff, rsp_stalled_in;
   logic [31:0]        rd_time_ff;
   logic signed [31:0] rd_angle_ff;

   logic        accept, cfg_wr;
   idx_type     rd_addr, wp_next, oldest;
   cnt_type     fill_next, step_plus;
   logic [31:0] age;
   logic [32:0] span;
   logic        verdict, out_free;

   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_THRESHOLD_DEG) ? {1'b0, thresh_ff} : window_ff;

   assign req_stall   = (state_ff != ST_IDLE);
   assign accept      = req_valid && !req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_stalled = rsp_stalled_ff;

   assign wp_next   = wp_ff + idx_type'(1);
   assign fill_next = (fill_ff < cnt_type'(DEPTH)) ? fill_ff + cnt_type'(1) : fill_ff;
   assign oldest    = wp_next - fill_next[IDX_W-1:0];
   assign step_plus = step_ff + cnt_type'(1);
   assign age       = now_ff - rd_time_ff;
   assign span      = {hi_ff[31], hi_ff} - {lo_ff[31], lo_ff};
   assign verdict   = (inwin_ff >= cnt_type'(2)) && (span <= {2'b00, thresh_ff});
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in       = state_ff;
      wp_in          = wp_ff;
      fill_in        = fill_ff;
      step_in        = step_ff;
      inwin_in       = inwin_ff;
      now_in         = now_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_stalled_in = rsp_stalled_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               wp_in    = wp_next;
               fill_in  = fill_next;
               now_in   = req_now_ms;
               lo_in    = req_angle_deg;
               hi_in    = req_angle_deg;
               inwin_in = cnt_type'(1);
               state_in = (fill_next < cnt_type'(2)) ? ST_DONE : ST_CHECK;
            end
         end
         ST_CHECK: begin
            step_in = cnt_type'(1);
            if (age < window_ff) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (age > window_ff) begin
               state_in = ST_DONE;
            end else begin
               if (rd_angle_ff < lo_ff) lo_in = rd_angle_ff;
               if (rd_angle_ff > hi_ff) hi_in = rd_angle_ff;
               inwin_in = inwin_ff + cnt_type'(1);
               step_in  = step_plus;
               if (step_plus == fill_ff) state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_stalled_in = verdict;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (cfg_wr) begin
         wp_in   = '0;
         fill_in = '0;
      end
   end

   // oldest entry on acceptance, else the next entry of the backward walk
   assign rd_addr = (state_ff == ST_IDLE) ? oldest
                                          : wp_ff - idx_type'(1) - step_in[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (accept) begin
         time_mem[wp_ff]  <= req_now_ms;
         angle_mem[wp_ff] <= req_angle_deg;
      end
      rd_time_ff  <= time_mem[rd_addr];
      rd_angle_ff <= angle_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         window_ff    <= WINDOW_MS_RESET;
         thresh_ff    <= THRESHOLD_DEG_RESET;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cfg_wr) begin
            if (csr_paddr[2] == REG_WINDOW_MS) window_ff <= csr_pwdata;
            else                               thresh_ff <= csr_pwdata[30:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      step_ff        <= step_in;
      inwin_ff       <= inwin_in;
      now_ff         <= now_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      rsp_stalled_ff <= rsp_stalled_in;
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= cnt_type'(DEPTH))
      else $error("fill count above depth");

   a_cfg_clears: assert property (@(posedge clock) disable iff (reset)
      cfg_wr |=> (fill_ff == '0) && (wp_ff == '0))
      else $error("register write did not clear history");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> (step_ff < fill_ff) && (step_ff != '0))
      else $error("walk beyond held samples");

   a_done_places: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) && out_free |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("verdict not placed");

endmodule

`default_nettype wire
